FILE: design/mm2_pkg.sv
// shared types and constants for the murmur2 hash block
`default_nettype none
package mm2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one command from the front to the back
  typedef struct packed {
    logic        seed_en;
    logic [31:0] seed;
    logic        word_en;
    logic [31:0] word;
    logic        fin_en;
    logic        tail_en;
    logic [23:0] tail;
  } cmd_t;

endpackage
`default_nettype wire

FILE: design/mm2_if.sv
// stream interfaces for message bytes in and hash values out
`default_nettype none
interface mm2_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        is_first;
  logic        is_last;
  logic        no_byte;
  logic [31:0] message_length;

  modport source (output valid, data_byte, is_first, is_last, no_byte, message_length,
                  input ready);
  modport sink   (input valid, data_byte, is_first, is_last, no_byte, message_length,
                  output ready);
endinterface

interface mm2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface
`default_nettype wire

FILE: design/mm2_front.sv
// front end: gathers bytes into words and issues commands
`default_nettype none
module mm2_front
  import mm2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mm2_in_if.sink    in_ch,
  input  wire logic full,
  output logic      push,
  output cmd_t      cmd
);

  logic [23:0] pending, pending_next;
  logic [1:0]  phase, phase_next;
  logic        accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    logic [23:0] pend;
    logic [1:0]  ph;
    pend = pending;
    ph   = phase;
    cmd  = '0;
    cmd.seed_en = in_ch.is_first;
    cmd.seed    = in_ch.message_length;
    if (in_ch.is_first) begin
      pend = '0;
      ph   = '0;
    end
    if (!in_ch.no_byte) begin
      case (ph)
        2'd0: begin
          pend[7:0] = in_ch.data_byte;
          ph        = 2'd1;
        end
        2'd1: begin
          pend[15:8] = in_ch.data_byte;
          ph         = 2'd2;
        end
        2'd2: begin
          pend[23:16] = in_ch.data_byte;
          ph          = 2'd3;
        end
        default: begin
          cmd.word_en = 1'b1;
          cmd.word    = {in_ch.data_byte, pend};
          pend        = '0;
          ph          = '0;
        end
      endcase
    end
    if (in_ch.is_last) begin
      cmd.fin_en  = 1'b1;
      cmd.tail_en = (ph != 2'd0);
      cmd.tail    = pend;
      pend        = '0;
      ph          = '0;
    end
    pending_next = pend;
    phase_next   = ph;
    push = accept && (cmd.seed_en || cmd.word_en || cmd.fin_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      phase   <= '0;
    end else if (accept) begin
      pending <= pending_next;
      phase   <= phase_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/mm2_cmd_fifo.sv
// short command queue between front and back
`default_nettype none
module mm2_cmd_fifo
  import mm2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output cmd_t      pop_cmd
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/mm2_back.sv
// back end: mixes words and finalizes with one shared multiplier
`default_nettype none
module mm2_back
  import mm2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  mm2_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_K1, ST_K2, ST_HM, ST_FTAIL, ST_FT2, ST_FM, ST_OUT
  } state_t;

  state_t      state;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic        fin_en;
  logic        tail_en;
  logic [23:0] tail;
  logic        out_valid;
  logic [31:0] hash_value;

  assign prod          = mul_a * MIX_MUL;
  assign cmd_pop       = (state == ST_IDLE) && cmd_valid;
  assign out_ch.valid      = out_valid;
  assign out_ch.hash_value = hash_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      h         <= '0;
      out_valid <= 1'b0;
    end else begin
      // the output state reloads the register itself when it frees up
      if (out_valid && out_ch.ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            h       <= cmd.seed_en ? cmd.seed : h;
            fin_en  <= cmd.fin_en;
            tail_en <= cmd.tail_en;
            tail    <= cmd.tail;
            mul_a   <= cmd.word;
            if (cmd.word_en) begin
              state <= ST_K1;
            end else if (cmd.fin_en) begin
              state <= ST_FTAIL;
            end
          end
        end
        ST_K1: begin
          mul_a <= prod ^ (prod >> MIX_SHIFT);
          state <= ST_K2;
        end
        ST_K2: begin
          k     <= prod;
          mul_a <= h;
          state <= ST_HM;
        end
        ST_HM: begin
          h     <= prod ^ k;
          state <= fin_en ? ST_FTAIL : ST_IDLE;
        end
        ST_FTAIL: begin
          if (tail_en) begin
            mul_a <= h ^ {8'b0, tail};
            state <= ST_FT2;
          end else begin
            mul_a <= h ^ (h >> FIN_SHIFT_A);
            state <= ST_FM;
          end
        end
        ST_FT2: begin
          mul_a <= prod ^ (prod >> FIN_SHIFT_A);
          state <= ST_FM;
        end
        ST_FM: begin
          k     <= prod;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            hash_value <= k ^ (k >> FIN_SHIFT_B);
            h          <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/murmur2_hash_32.sv
// top level of the streaming murmur2 32-bit hash
//
// Streaming MurmurHash2 (32-bit, m = 0x5bd1e995) over a message delivered
// one byte per transfer on in_ch. The transfer with is_first set seeds the
// hash with message_length; bytes are packed little-endian into words, and
// the transfer with is_last set produces exactly one hash_value transfer on
// out_ch. A transfer with no_byte set carries no byte (for the empty message,
// set is_first, is_last and no_byte together). After a last transfer the
// state returns to a zero seed. Timing: the front takes one byte per cycle
// whenever the four-entry command queue has room. The back runs one shared
// 32x32 multiplier with a registered operand: a seed-only command is just a
// load, a full word is a load plus three multiplies (states K1, K2 and HM),
// and the finish runs FTAIL, then FT2 when tail bytes are left, then FM,
// then the output state that loads the output register. The sustained rate
// is one byte per cycle within a message, set by the word mixing loop; each
// message adds the finalization states at its end. The output register
// frees the back while a finished hash waits for out_ch.ready.
`default_nettype none
module murmur2_hash_32
  import mm2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mm2_in_if.sink    in_ch,
  mm2_out_if.source out_ch
);

  // front to queue
  logic full;
  logic push;
  cmd_t push_cmd;

  // queue to back
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  mm2_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .cmd   (push_cmd)
  );

  mm2_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  mm2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
